### design/pbts_pkg.sv
package pbts_pkg;

   localparam int MAX_TASKS_DEF       = 16;
   localparam int PRIORITY_LEVELS_DEF = 4;
   localparam int EVENT_COUNT_DEF     = 8;
   localparam int STACK_SLOTS_DEF     = 8;

   localparam int         SIZE_CLASSES = 3;
   localparam int         EVENT_ID_MAX = 8;
   localparam logic [4:0] IDLE_CODE    = 5'd16;

   typedef enum logic [1:0] {
      FUNC_CREATE = 2'd0,
      FUNC_WAIT   = 2'd1,
      FUNC_EMIT   = 2'd2,
      FUNC_TICK   = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      CLASS_SMALL  = 2'd0,
      CLASS_MEDIUM = 2'd1,
      CLASS_LARGE  = 2'd2
   } size_class_type;

   typedef struct packed {
      func_type   func;
      logic [1:0] priority_req;
      logic [1:0] size_class;
      logic [2:0] event_id;
      logic [4:0] current_task;
   } req_type;

   typedef struct packed {
      logic [4:0] task_index;
      logic [2:0] stack_slot;
      logic       ok;
      logic       switch_request;
   } rsp_type;

endpackage

### design/priority_bitmap_task_scheduler_unit.sv
// The request is registered at the accepting edge and the response at the next edge;
// rsp_valid is registered from req_valid_ff and marks the response in rsp_data.
// Throughput: one request per cycle; busy is always low.
// Each request is registered, then decoded combinationally and applied to the masks at the next edge.
// Synchronous reset clears ready, waiter and pool masks; task priorities stay
// undefined until a create writes them. The receiver cannot stall.
module priority_bitmap_task_scheduler_unit
   import pbts_pkg::*;
#(
   parameter int MAX_TASKS       = MAX_TASKS_DEF,
   parameter int PRIORITY_LEVELS = PRIORITY_LEVELS_DEF,
   parameter int EVENT_COUNT     = EVENT_COUNT_DEF,
   parameter int STACK_SLOTS     = STACK_SLOTS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   localparam int TW       = $clog2(MAX_TASKS);
   localparam int PW       = $clog2(PRIORITY_LEVELS);
   localparam int SW       = (STACK_SLOTS > 1) ? $clog2(STACK_SLOTS) : 1;
   localparam int EV_DEPTH = (EVENT_COUNT < EVENT_ID_MAX) ? EVENT_COUNT : EVENT_ID_MAX;
   localparam int EW       = (EV_DEPTH > 1) ? $clog2(EV_DEPTH) : 1;

   logic                   req_valid_ff;
   req_type                req_ff;
   logic                   rsp_valid_ff;
   rsp_type                rsp_ff, rsp_in;

   logic [MAX_TASKS-1:0]   ready_ff   [PRIORITY_LEVELS];
   logic [MAX_TASKS-1:0]   ready_in   [PRIORITY_LEVELS];
   logic [MAX_TASKS-1:0]   waiters_ff [EV_DEPTH];
   logic [MAX_TASKS-1:0]   waiters_in [EV_DEPTH];
   logic [MAX_TASKS-1:0]   used_ff, used_in;
   logic [STACK_SLOTS-1:0] stack_ff   [SIZE_CLASSES];
   logic [STACK_SLOTS-1:0] stack_in   [SIZE_CLASSES];
   logic [PW-1:0]          prio_ff    [MAX_TASKS];

   logic                   prio_we;
   logic [TW-1:0]          prio_waddr;
   logic [PW-1:0]          prio_wdata;

   logic [MAX_TASKS-1:0]   ready_union;

   assign busy      = 1'b0;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      int                     prio_int;
      logic [PW-1:0]          prio_idx;
      logic [1:0]             cls;
      logic [MAX_TASKS-1:0]   free_tasks;
      logic [STACK_SLOTS-1:0] free_slots;
      logic [TW-1:0]          t_idx;
      logic [SW-1:0]          s_idx;
      logic                   ev_ok;
      logic [EW-1:0]          ev_idx;
      logic [TW-1:0]          cur_idx;
      logic [PW-1:0]          cur_prio;
      logic [MAX_TASKS-1:0]   sel_mask;
      logic                   any_ready;
      logic [TW-1:0]          next_idx;
      logic [4:0]             next_task;

      ready_in   = ready_ff;
      waiters_in = waiters_ff;
      used_in    = used_ff;
      stack_in   = stack_ff;
      rsp_in     = '0;
      prio_we    = 1'b0;

      prio_int = int'(req_ff.priority_req);
      if (prio_int >= PRIORITY_LEVELS) begin
         prio_int = prio_int - PRIORITY_LEVELS;
      end
      prio_idx = PW'(prio_int);

      cls = (req_ff.size_class inside {CLASS_LARGE, 2'd3}) ? CLASS_LARGE : req_ff.size_class;

      free_tasks = ~used_ff;
      free_slots = ~stack_ff[cls];
      t_idx = '0;
      for (int i = MAX_TASKS - 1; i >= 0; i--) begin
         if (free_tasks[i]) begin
            t_idx = TW'(i);
         end
      end
      s_idx = '0;
      for (int i = STACK_SLOTS - 1; i >= 0; i--) begin
         if (free_slots[i]) begin
            s_idx = SW'(i);
         end
      end

      prio_waddr = t_idx;
      prio_wdata = prio_idx;

      ev_ok   = int'(req_ff.event_id) < EVENT_COUNT;
      ev_idx  = EW'(req_ff.event_id);
      cur_idx = TW'(req_ff.current_task);
      cur_prio = prio_ff[cur_idx];

      sel_mask = '0;
      for (int l = 0; l < PRIORITY_LEVELS; l++) begin
         if (|ready_ff[l]) begin
            sel_mask = ready_ff[l];
         end
      end
      any_ready = |sel_mask;
      next_idx  = '0;
      for (int i = MAX_TASKS - 1; i >= 0; i--) begin
         if (sel_mask[i]) begin
            next_idx = TW'(i);
         end
      end
      next_task = any_ready ? 5'(next_idx) : IDLE_CODE;

      if (req_valid_ff) begin
         case (req_ff.func)
            FUNC_CREATE: begin
               if (|free_tasks && |free_slots) begin
                  stack_in[cls][s_idx] = 1'b1;
                  used_in[t_idx]       = 1'b1;
                  ready_in[prio_idx][t_idx] = 1'b1;
                  prio_we              = 1'b1;
                  rsp_in.task_index    = 5'(t_idx);
                  rsp_in.stack_slot    = 3'(s_idx);
                  rsp_in.ok            = 1'b1;
               end
            end
            FUNC_WAIT: begin
               if (int'(req_ff.current_task) < MAX_TASKS && ev_ok) begin
                  waiters_in[ev_idx][cur_idx] = 1'b1;
                  ready_in[cur_prio][cur_idx] = 1'b0;
               end
            end
            FUNC_EMIT: begin
               if (ev_ok) begin
                  for (int l = 0; l < PRIORITY_LEVELS; l++) begin
                     for (int t = 0; t < MAX_TASKS; t++) begin
                        if (waiters_ff[ev_idx][t] && prio_ff[t] == PW'(l)) begin
                           ready_in[l][t] = 1'b1;
                        end
                     end
                  end
                  waiters_in[ev_idx] = '0;
               end
            end
            FUNC_TICK: begin
               rsp_in.task_index     = next_task;
               rsp_in.switch_request = next_task != req_ff.current_task;
            end
            default: begin
               rsp_in = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         used_ff      <= '0;
         for (int l = 0; l < PRIORITY_LEVELS; l++) begin
            ready_ff[l] <= '0;
         end
         for (int e = 0; e < EV_DEPTH; e++) begin
            waiters_ff[e] <= '0;
         end
         for (int c = 0; c < SIZE_CLASSES; c++) begin
            stack_ff[c] <= '0;
         end
      end else begin
         req_valid_ff <= start && !busy;
         rsp_valid_ff <= req_valid_ff;
         used_ff      <= used_in;
         ready_ff     <= ready_in;
         waiters_ff   <= waiters_in;
         stack_ff     <= stack_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy) begin
         req_ff <= req_data;
      end
      rsp_ff <= rsp_in;
      if (prio_we) begin
         prio_ff[prio_waddr] <= prio_wdata;
      end
   end

   always_comb begin
      ready_union = '0;
      for (int l = 0; l < PRIORITY_LEVELS; l++) begin
         ready_union = ready_union | ready_ff[l];
      end
      for (int e = 0; e < EV_DEPTH; e++) begin
         ready_union = ready_union | waiters_ff[e];
      end
   end

   a_ok_xor_switch: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ff.ok && rsp_ff.switch_request))
      else $error("ok and switch_request raised together");

   a_only_used_tasks: assert property (@(posedge clock) disable iff (reset)
      (ready_union & ~used_ff) == '0)
      else $error("ready or waiting task not in use");

   a_create_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.ok |-> int'(rsp_ff.task_index) < MAX_TASKS)
      else $error("created task index out of range");

   a_rsp_follows_req: assert property (@(posedge clock) disable iff (reset)
      req_valid_ff && req_ff.func == FUNC_WAIT |=> rsp_valid_ff && rsp_ff == '0)
      else $error("wait produced a nonzero response");

endmodule
